// File: sv/assert_macros.svh
// Assertion macros shared by the stepper RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(name, trig, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) else $error(msg);

`endif

// File: sv/l3b_pkg.sv
// Shared types and constants for the 3D Bresenham line stepper.
// No dependencies; used by l3b_core and the top level.
`default_nettype none

package l3b_pkg;

   // Default coordinate width for each color axis.
   localparam int COORD_BITS_DEF = 8;

   // Input operation selector.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   // Result status code.
   typedef enum logic [1:0] {
      ST_POINT  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   // Major axis of the active line.
   typedef enum logic [1:0] {
      AX_R = 2'd0,
      AX_G = 2'd1,
      AX_B = 2'd2
   } axis_type;

endpackage

`default_nettype wire

// File: sv/l3b_minor.sv
// Bresenham error update for one minor axis.
// Depends on nothing but its parameter; instantiated twice by l3b_core.
`default_nettype none

module l3b_minor #(
   parameter int COORD_BITS = 8
) (
   input  wire logic signed [COORD_BITS+1:0] err_i,
   input  wire logic        [COORD_BITS-1:0] dmin_i,
   input  wire logic        [COORD_BITS-1:0] dmaj_i,
   output      logic signed [COORD_BITS+1:0] err_o,
   output      logic                         adv_o
);

   localparam int EW = COORD_BITS + 2;

   logic signed [EW:0] err_ext;
   logic signed [EW:0] twice_min;
   logic signed [EW:0] twice_maj;
   logic signed [EW:0] sum;
   logic               not_pos;

   // A non-positive error grows by twice the minor delta; otherwise the
   // minor coordinate advances and twice the major delta is taken off as well.
   always_comb begin
      err_ext   = {err_i[EW-1], err_i};
      twice_min = $signed({2'b00, dmin_i, 1'b0});
      twice_maj = $signed({2'b00, dmaj_i, 1'b0});
      not_pos   = err_i[EW-1] || (err_i == '0);
      if (not_pos) begin
         sum = err_ext + twice_min;
      end else begin
         sum = err_ext + twice_min - twice_maj;
      end
      err_o = sum[EW-1:0];
      adv_o = !not_pos;
   end

endmodule

`default_nettype wire

// File: sv/l3b_core.sv
// Line state registers and the single-pass load and step logic.
// Depends on l3b_pkg and l3b_minor; results go to l3b_out_buf.
`default_nettype none

`include "assert_macros.svh"

module l3b_core #(
   parameter int COORD_BITS = l3b_pkg::COORD_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept_i,
   input  wire l3b_pkg::op_type           opcode_i,
   input  wire logic [COORD_BITS-1:0]     start_r_i,
   input  wire logic [COORD_BITS-1:0]     start_g_i,
   input  wire logic [COORD_BITS-1:0]     start_b_i,
   input  wire logic [COORD_BITS-1:0]     end_r_i,
   input  wire logic [COORD_BITS-1:0]     end_g_i,
   input  wire logic [COORD_BITS-1:0]     end_b_i,
   output      logic                      res_valid_o,
   // Fields from bit 0 up: point_r, point_g, point_b, last_point, status.
   output      logic [3*COORD_BITS+2:0]   res_data_o
);

   localparam int CB = COORD_BITS;
   localparam int EW = COORD_BITS + 2;

   // Line state.
   logic [CB-1:0]         cur_r_ff, cur_r_in;
   logic [CB-1:0]         cur_g_ff, cur_g_in;
   logic [CB-1:0]         cur_b_ff, cur_b_in;
   logic [CB-1:0]         major_end_ff, major_end_in;
   logic [CB-1:0]         delta_r_ff, delta_r_in;
   logic [CB-1:0]         delta_g_ff, delta_g_in;
   logic [CB-1:0]         delta_b_ff, delta_b_in;
   l3b_pkg::axis_type     major_axis_ff, major_axis_in;
   logic signed [EW-1:0]  err_first_ff, err_first_in;
   logic signed [EW-1:0]  err_second_ff, err_second_in;
   logic                  line_active_ff, line_active_in;

   // Load decode.
   logic [CB-1:0]         ld_dr, ld_dg, ld_db;
   logic [CB-1:0]         ld_dmaj, ld_dm1, ld_dm2, ld_emaj;
   l3b_pkg::axis_type     ld_axis;
   logic                  load_bad;

   // Step decode.
   logic [CB-1:0]         st_dmaj, st_dm1, st_dm2;
   logic signed [EW-1:0]  st_err1, st_err2;
   logic                  st_adv1, st_adv2;
   logic [CB-1:0]         st_r, st_g, st_b, st_maj;

   // Result fields.
   logic [CB-1:0]         pt_r, pt_g, pt_b;
   logic                  pt_last;
   l3b_pkg::status_type   pt_status;

   // Qualifiers used by the assertions.
   logic                  idle_step;
   logic                  reject_load;
   logic [3*CB+EW:0]      held_state;

   // Load: deltas, major axis choice (ties go to R, then G) and minor deltas.
   always_comb begin
      load_bad = (end_r_i < start_r_i) || (end_g_i < start_g_i) || (end_b_i < start_b_i);
      ld_dr    = end_r_i - start_r_i;
      ld_dg    = end_g_i - start_g_i;
      ld_db    = end_b_i - start_b_i;
      priority if (ld_dr >= ld_dg && ld_dr >= ld_db) begin
         ld_axis = l3b_pkg::AX_R;
      end else if (ld_dg >= ld_db) begin
         ld_axis = l3b_pkg::AX_G;
      end else begin
         ld_axis = l3b_pkg::AX_B;
      end
      unique case (ld_axis)
         l3b_pkg::AX_G: begin
            ld_dmaj = ld_dg; ld_emaj = end_g_i; ld_dm1 = ld_dr; ld_dm2 = ld_db;
         end
         l3b_pkg::AX_B: begin
            ld_dmaj = ld_db; ld_emaj = end_b_i; ld_dm1 = ld_dr; ld_dm2 = ld_dg;
         end
         default: begin
            ld_dmaj = ld_dr; ld_emaj = end_r_i; ld_dm1 = ld_dg; ld_dm2 = ld_db;
         end
      endcase
   end

   // Step: pick the stored deltas by major axis.
   always_comb begin
      unique case (major_axis_ff)
         l3b_pkg::AX_G: begin
            st_dmaj = delta_g_ff; st_dm1 = delta_r_ff; st_dm2 = delta_b_ff;
         end
         l3b_pkg::AX_B: begin
            st_dmaj = delta_b_ff; st_dm1 = delta_r_ff; st_dm2 = delta_g_ff;
         end
         default: begin
            st_dmaj = delta_r_ff; st_dm1 = delta_g_ff; st_dm2 = delta_b_ff;
         end
      endcase
   end

   l3b_minor #(.COORD_BITS(CB)) u_minor_first (
      .err_i  (err_first_ff),
      .dmin_i (st_dm1),
      .dmaj_i (st_dmaj),
      .err_o  (st_err1),
      .adv_o  (st_adv1)
   );

   l3b_minor #(.COORD_BITS(CB)) u_minor_second (
      .err_i  (err_second_ff),
      .dmin_i (st_dm2),
      .dmaj_i (st_dmaj),
      .err_o  (st_err2),
      .adv_o  (st_adv2)
   );

   // Step: advance the major axis and each minor axis that is due.
   always_comb begin
      unique case (major_axis_ff)
         l3b_pkg::AX_G: begin
            st_g = cur_g_ff + {{(CB-1){1'b0}}, 1'b1};
            st_r = cur_r_ff + {{(CB-1){1'b0}}, st_adv1};
            st_b = cur_b_ff + {{(CB-1){1'b0}}, st_adv2};
            st_maj = st_g;
         end
         l3b_pkg::AX_B: begin
            st_b = cur_b_ff + {{(CB-1){1'b0}}, 1'b1};
            st_r = cur_r_ff + {{(CB-1){1'b0}}, st_adv1};
            st_g = cur_g_ff + {{(CB-1){1'b0}}, st_adv2};
            st_maj = st_b;
         end
         default: begin
            st_r = cur_r_ff + {{(CB-1){1'b0}}, 1'b1};
            st_g = cur_g_ff + {{(CB-1){1'b0}}, st_adv1};
            st_b = cur_b_ff + {{(CB-1){1'b0}}, st_adv2};
            st_maj = st_r;
         end
      endcase
   end

   // Next state and the result for the item taken in this cycle.
   always_comb begin
      cur_r_in       = cur_r_ff;
      cur_g_in       = cur_g_ff;
      cur_b_in       = cur_b_ff;
      major_end_in   = major_end_ff;
      delta_r_in     = delta_r_ff;
      delta_g_in     = delta_g_ff;
      delta_b_in     = delta_b_ff;
      major_axis_in  = major_axis_ff;
      err_first_in   = err_first_ff;
      err_second_in  = err_second_ff;
      line_active_in = line_active_ff;
      pt_r           = '0;
      pt_g           = '0;
      pt_b           = '0;
      pt_last        = 1'b0;
      pt_status      = l3b_pkg::ST_POINT;
      if (accept_i) begin
         if (opcode_i == l3b_pkg::OP_LOAD) begin
            if (load_bad) begin
               line_active_in = 1'b0;
               pt_status      = l3b_pkg::ST_REJECT;
            end else begin
               cur_r_in       = start_r_i;
               cur_g_in       = start_g_i;
               cur_b_in       = start_b_i;
               delta_r_in     = ld_dr;
               delta_g_in     = ld_dg;
               delta_b_in     = ld_db;
               major_axis_in  = ld_axis;
               major_end_in   = ld_emaj;
               err_first_in   = $signed({1'b0, ld_dm1, 1'b0}) - $signed({2'b00, ld_dmaj});
               err_second_in  = $signed({1'b0, ld_dm2, 1'b0}) - $signed({2'b00, ld_dmaj});
               line_active_in = (ld_dmaj != '0);
               pt_r           = start_r_i;
               pt_g           = start_g_i;
               pt_b           = start_b_i;
               pt_last        = (ld_dmaj == '0);
            end
         end else if (!line_active_ff) begin
            pt_status = l3b_pkg::ST_IDLE;
         end else begin
            cur_r_in       = st_r;
            cur_g_in       = st_g;
            cur_b_in       = st_b;
            err_first_in   = st_err1;
            err_second_in  = st_err2;
            pt_r           = st_r;
            pt_g           = st_g;
            pt_b           = st_b;
            pt_last        = (st_maj == major_end_ff);
            line_active_in = (st_maj != major_end_ff);
         end
      end
      res_valid_o = accept_i;
      res_data_o  = {pt_status, pt_last, pt_b, pt_g, pt_r};
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_r_ff       <= '0;
         cur_g_ff       <= '0;
         cur_b_ff       <= '0;
         major_end_ff   <= '0;
         delta_r_ff     <= '0;
         delta_g_ff     <= '0;
         delta_b_ff     <= '0;
         major_axis_ff  <= l3b_pkg::AX_R;
         err_first_ff   <= '0;
         err_second_ff  <= '0;
         line_active_ff <= 1'b0;
      end else begin
         cur_r_ff       <= cur_r_in;
         cur_g_ff       <= cur_g_in;
         cur_b_ff       <= cur_b_in;
         major_end_ff   <= major_end_in;
         delta_r_ff     <= delta_r_in;
         delta_g_ff     <= delta_g_in;
         delta_b_ff     <= delta_b_in;
         major_axis_ff  <= major_axis_in;
         err_first_ff   <= err_first_in;
         err_second_ff  <= err_second_in;
         line_active_ff <= line_active_in;
      end
   end

   // Conditions and the watched state for the assertions below.
   assign idle_step   = accept_i && opcode_i == l3b_pkg::OP_STEP && !line_active_ff;
   assign reject_load = accept_i && opcode_i == l3b_pkg::OP_LOAD && load_bad;
   assign held_state  = {line_active_ff, cur_r_ff, cur_g_ff, cur_b_ff, err_first_ff};

   // A step with no active line leaves the whole line state untouched.
   `ASSERT_NEXT(a_idle_step_holds, idle_step, $stable(held_state), "idle step changed line state")
   // A rejected load always drops the active line.
   `ASSERT_NEXT(a_reject_drops_line, reject_load, !line_active_ff, "rejected load kept a line")

endmodule

`default_nettype wire

// File: sv/l3b_out_buf.sv
// Two-entry result buffer: an output register and a skid register.
// Depends on nothing but its parameter; fed by l3b_core.
`default_nettype none

`include "assert_macros.svh"

module l3b_out_buf #(
   parameter int DATA_BITS = 27
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid_i,
   input  wire logic [DATA_BITS-1:0] in_data_i,
   output      logic                 in_ready_o,
   output      logic                 out_valid_o,
   input  wire logic                 out_ready_i,
   output      logic [DATA_BITS-1:0] out_data_o
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [DATA_BITS-1:0] main_data_ff, main_data_in;
   logic [DATA_BITS-1:0] skid_data_ff, skid_data_in;
   logic                 pop;

   // Input is taken whenever the skid entry is free.
   assign in_ready_o  = !skid_valid_ff;
   assign out_valid_o = main_valid_ff;
   assign out_data_o  = main_data_ff;

   // Refill the output register from the skid entry first, then from input.
   always_comb begin
      pop           = main_valid_ff && out_ready_i;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop && skid_valid_ff) begin
         main_data_in  = skid_data_ff;
         skid_valid_in = 1'b0;
      end else if (in_valid_i) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = in_data_i;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data_i;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid entry is only ever filled behind a full output register.
   `ASSERT_ALWAYS(a_skid_behind_main, !skid_valid_ff || main_valid_ff, "skid entry valid with empty output register")
   // No transfer arrives while both entries are full.
   `ASSERT_ALWAYS(a_no_push_when_full, !(in_valid_i && skid_valid_ff), "transfer into a full buffer")
   // A transfer into an empty buffer shows up at the output next cycle.
   `ASSERT_NEXT(a_empty_push_shows, in_valid_i && !main_valid_ff, main_valid_ff && main_data_ff == $past(in_data_i), "result lost on empty buffer")

endmodule

`default_nettype wire

// File: sv/line_3d_bresenham_stepper.sv
// Top level of the 3D Bresenham line stepper over RGB coordinates.
// Depends on l3b_pkg, l3b_core (with l3b_minor) and l3b_out_buf.
//
//   Channel  Dir  tdata (bit 0 up)                         tuser      tlast
//   req_     in   start_r start_g start_b end_r end_g end_b  opcode     -
//   rsp_     out  point_r point_g point_b                  status     last_point
//
// One item per cycle sustained while rsp_ takes results; each result is registered in the output
// buffer before it appears on rsp_. The line state update and the error-term adds sit between
// the state registers and the output register.
// Reset is synchronous and active high; it clears the line state and empties the buffer.
// A two-entry output buffer absorbs a stall: req_tready falls only when both entries hold
// results that rsp_ has not taken.
`default_nettype none

module line_3d_bresenham_stepper #(
   parameter int COORD_BITS = l3b_pkg::COORD_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   // start_r, start_g, start_b, end_r, end_g, end_b, then zero fill.
   input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // opcode.
   input  wire logic                                  req_tuser,
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // point_r, point_g, point_b, then zero fill.
   output      logic [((3*COORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   output      logic                                  rsp_tlast,
   // status.
   output      logic [1:0]                            rsp_tuser
);

   localparam int CB     = COORD_BITS;
   localparam int RES_W  = 3*CB + 3;
   localparam int RSP_DW = ((3*CB+7)/8)*8;

   logic               accept;
   logic               res_valid;
   logic [RES_W-1:0]   res_data;
   logic [RES_W-1:0]   out_data;
   l3b_pkg::op_type    opcode;

   // Input transfer.
   assign accept = req_tvalid && req_tready;
   assign opcode = l3b_pkg::op_type'(req_tuser);

   l3b_core #(.COORD_BITS(CB)) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept_i    (accept),
      .opcode_i    (opcode),
      .start_r_i   (req_tdata[0*CB +: CB]),
      .start_g_i   (req_tdata[1*CB +: CB]),
      .start_b_i   (req_tdata[2*CB +: CB]),
      .end_r_i     (req_tdata[3*CB +: CB]),
      .end_g_i     (req_tdata[4*CB +: CB]),
      .end_b_i     (req_tdata[5*CB +: CB]),
      .res_valid_o (res_valid),
      .res_data_o  (res_data)
   );

   l3b_out_buf #(.DATA_BITS(RES_W)) u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .in_valid_i  (res_valid),
      .in_data_i   (res_data),
      .in_ready_o  (req_tready),
      .out_valid_o (rsp_tvalid),
      .out_ready_i (rsp_tready),
      .out_data_o  (out_data)
   );

   // Unpack the buffered result onto the stream ports.
   assign rsp_tdata = RSP_DW'(out_data[3*CB-1:0]);
   assign rsp_tlast = out_data[3*CB];
   assign rsp_tuser = out_data[3*CB+2:3*CB+1];

endmodule

`default_nettype wire
